### rtl/core/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, widths and helpers of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int CW = 16;            // component width
	localparam int FB = 8;             // fraction bits
	localparam int PW = 2 * CW;        // product width
	localparam int MW = 2 * CW + 1;    // magnitude / denominator width
	localparam int QW = CW + 1;        // quotient bits produced by the divider
	localparam int RW = MW + QW;       // divider remainder width

	localparam logic [2:0] ACT_ADD  = 3'd0;
	localparam logic [2:0] ACT_SUB  = 3'd1;
	localparam logic [2:0] ACT_MUL  = 3'd2;
	localparam logic [2:0] ACT_DIV  = 3'd3;
	localparam logic [2:0] ACT_CONJ = 3'd4;
	localparam logic [2:0] ACT_MOD  = 3'd5;
	localparam logic [2:0] ACT_EQ   = 3'd6;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;

	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW+1:0] WMAX = {3'b000, {(CW-1){1'b1}}};
	localparam logic signed [CW+1:0] WMIN = {3'b111, {(CW-1){1'b0}}};

	typedef enum logic [1:0] {
		SRC_QUICK,
		SRC_DIV,
		SRC_SQRT
	} src_t;

	typedef struct packed {
		logic [2:0]           action;
		logic signed [CW-1:0] a_real;
		logic signed [CW-1:0] a_imag;
		logic signed [CW-1:0] b_real;
		logic signed [CW-1:0] b_imag;
	} item_t;

	typedef struct packed {
		logic signed [CW-1:0] res_real;
		logic signed [CW-1:0] res_imag;
		logic                 equal_flag;
		logic [1:0]           status;
	} result_t;

	// Per-item information that rides alongside the divider and root pipes.
	typedef struct packed {
		src_t                 src;
		logic                 neg_re;
		logic                 neg_im;
		logic signed [CW-1:0] re;
		logic signed [CW-1:0] im;
		logic                 eq;
		logic [1:0]           st;
	} side_t;

	// Saturate a widened value to a component; the top bit flags saturation.
	function automatic logic [CW:0] clamp(input logic signed [CW+1:0] x);
		logic [CW:0] r;
		if (x > WMAX) begin
			r = {1'b1, CMAX};
		end else if (x < WMIN) begin
			r = {1'b1, CMIN};
		end else begin
			r = {1'b0, x[CW-1:0]};
		end
		return r;
	endfunction

endpackage

### rtl/core/cau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// Two front stages: products and simple results, then sums and magnitudes.
// ----------------------------------------------------------------------------
module cau_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  cau_pkg::item_t              item,
	output logic                        v_s2,
	output cau_pkg::side_t              side_s2,
	output logic [cau_pkg::MW-1:0]      mag_re_s2,
	output logic [cau_pkg::MW-1:0]      mag_im_s2,
	output logic [cau_pkg::MW-1:0]      den_s2,
	output logic [cau_pkg::PW-1:0]      modsum_s2
);

	localparam int CW = cau_pkg::CW;
	localparam int PW = cau_pkg::PW;
	localparam int MW = cau_pkg::MW;

	logic                 v_s1;
	logic                 is_mul_s1;
	cau_pkg::side_t       side_s1;
	logic signed [PW-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [PW-1:0] sq_ar_s1, sq_ai_s1, sq_br_s1, sq_bi_s1;

	logic signed [CW+1:0] war, wai, wbr, wbi;
	logic [CW:0]          c_re, c_im;
	cau_pkg::side_t       side_in;

	assign war = {{2{item.a_real[CW-1]}}, item.a_real};
	assign wai = {{2{item.a_imag[CW-1]}}, item.a_imag};
	assign wbr = {{2{item.b_real[CW-1]}}, item.b_real};
	assign wbi = {{2{item.b_imag[CW-1]}}, item.b_imag};

	always_comb begin
		c_re = '0;
		c_im = '0;
		side_in = '{src: cau_pkg::SRC_QUICK, neg_re: 1'b0, neg_im: 1'b0,
			re: '0, im: '0, eq: 1'b0, st: cau_pkg::ST_OK};
		case (item.action)
			cau_pkg::ACT_ADD: begin
				c_re = cau_pkg::clamp(war + wbr);
				c_im = cau_pkg::clamp(wai + wbi);
			end
			cau_pkg::ACT_SUB: begin
				c_re = cau_pkg::clamp(war - wbr);
				c_im = cau_pkg::clamp(wai - wbi);
			end
			cau_pkg::ACT_MUL: begin
				side_in.src = cau_pkg::SRC_DIV;
			end
			cau_pkg::ACT_DIV: begin
				if (item.b_real == '0 && item.b_imag == '0) begin
					side_in.st = cau_pkg::ST_DIVZ;
				end else begin
					side_in.src = cau_pkg::SRC_DIV;
				end
			end
			cau_pkg::ACT_CONJ: begin
				c_re = {1'b0, item.a_real};
				c_im = cau_pkg::clamp(-wai);
			end
			cau_pkg::ACT_MOD: begin
				side_in.src = cau_pkg::SRC_SQRT;
			end
			cau_pkg::ACT_EQ: begin
				side_in.eq = (item.a_real == item.b_real) && (item.a_imag == item.b_imag);
			end
			default: begin
			end
		endcase
		side_in.re = c_re[CW-1:0];
		side_in.im = c_im[CW-1:0];
		if (c_re[CW] || c_im[CW]) begin
			side_in.st = cau_pkg::ST_SAT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s1   <= side_in;
		is_mul_s1 <= (item.action == cau_pkg::ACT_MUL);
		p_rr_s1   <= item.a_real * item.b_real;
		p_ii_s1   <= item.a_imag * item.b_imag;
		p_ri_s1   <= item.a_real * item.b_imag;
		p_ir_s1   <= item.a_imag * item.b_real;
		sq_ar_s1  <= item.a_real * item.a_real;
		sq_ai_s1  <= item.a_imag * item.a_imag;
		sq_br_s1  <= item.b_real * item.b_real;
		sq_bi_s1  <= item.b_imag * item.b_imag;
	end

	logic signed [PW:0] num_re, num_im;
	logic signed [PW:0] x_rr, x_ii, x_ri, x_ir;
	cau_pkg::side_t     side_nx;

	assign x_rr = {p_rr_s1[PW-1], p_rr_s1};
	assign x_ii = {p_ii_s1[PW-1], p_ii_s1};
	assign x_ri = {p_ri_s1[PW-1], p_ri_s1};
	assign x_ir = {p_ir_s1[PW-1], p_ir_s1};

	// Multiply uses A*B; divide uses A*conj(B).
	assign num_re = is_mul_s1 ? (x_rr - x_ii) : (x_rr + x_ii);
	assign num_im = is_mul_s1 ? (x_ri + x_ir) : (x_ir - x_ri);

	always_comb begin
		side_nx        = side_s1;
		side_nx.neg_re = num_re[PW];
		side_nx.neg_im = num_im[PW];
	end

	always_ff @(posedge clk) begin
		side_s2   <= side_nx;
		mag_re_s2 <= num_re[PW] ? MW'(-num_re) : MW'(num_re);
		mag_im_s2 <= num_im[PW] ? MW'(-num_im) : MW'(num_im);
		den_s2    <= is_mul_s1 ? (MW'(1) << (2 * cau_pkg::FB))
			: (MW'($unsigned(sq_br_s1)) + MW'($unsigned(sq_bi_s1)));
		modsum_s2 <= $unsigned(sq_ar_s1) + $unsigned(sq_ai_s1);
	end

endmodule

### rtl/core/cau_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_divider
// Pipelined restoring divider, one quotient bit per stage, with overflow check.
// ----------------------------------------------------------------------------
module cau_divider (
	input  logic                   clk,
	input  logic [cau_pkg::MW-1:0] mag,
	input  logic [cau_pkg::MW-1:0] den,
	output logic [cau_pkg::QW-1:0] quo,
	output logic                   ovf
);

	localparam int MW = cau_pkg::MW;
	localparam int QW = cau_pkg::QW;
	localparam int RW = cau_pkg::RW;

	logic [RW-1:0] rem_s [0:QW];
	logic [MW-1:0] den_s [0:QW];
	logic [QW-1:0] quo_s [0:QW];
	logic          ovf_s [0:QW];

	logic [RW-1:0] num;
	assign num = RW'(mag) << (cau_pkg::FB + 1);

	// The dividend is the magnitude shifted left by FB + 1: the fraction bits plus one extra bit for rounding.
	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		den_s[0] <= den;
		quo_s[0] <= '0;
		ovf_s[0] <= num >= (RW'(den) << QW);
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [RW-1:0] dsh;
		logic          ge;
		assign dsh = RW'(den_s[k]) << (QW - 1 - k);
		assign ge  = rem_s[k] >= dsh;
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? (rem_s[k] - dsh) : rem_s[k];
			den_s[k+1] <= den_s[k];
			quo_s[k+1] <= {quo_s[k][QW-2:0], ge};
			ovf_s[k+1] <= ovf_s[k];
		end
	end

	assign quo = quo_s[QW];
	assign ovf = ovf_s[QW];

endmodule

### rtl/core/cau_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_sqrt
// Pipelined digit-by-digit square root with round to nearest.
// ----------------------------------------------------------------------------
module cau_sqrt (
	input  logic                   clk,
	input  logic [cau_pkg::PW-1:0] sum,
	output logic [cau_pkg::CW:0]   root
);

	localparam int CW = cau_pkg::CW;
	localparam int PW = cau_pkg::PW;

	logic [PW-1:0] s_s [0:CW-1];
	logic [PW-1:0] r_s [0:CW-1];
	logic [CW:0]   fin_s;
	logic [CW:0]   root_s;

	for (genvar k = 0; k < CW; k++) begin : g_step
		logic [PW-1:0] s_cur, r_cur, bitv, t;
		logic          ge;
		if (k == 0) begin : g_first
			assign s_cur = sum;
			assign r_cur = '0;
		end else begin : g_next
			assign s_cur = s_s[k-1];
			assign r_cur = r_s[k-1];
		end
		assign bitv = PW'(1) << (2 * (CW - 1 - k));
		assign t    = r_cur + bitv;
		assign ge   = s_cur >= t;
		always_ff @(posedge clk) begin
			s_s[k] <= ge ? (s_cur - t) : s_cur;
			r_s[k] <= ge ? ((r_cur >> 1) + bitv) : (r_cur >> 1);
		end
	end

	// A remainder above the root means the true root lies past the half point.
	always_ff @(posedge clk) begin
		fin_s  <= (s_s[CW-1] > r_s[CW-1]) ? (CW+1)'(r_s[CW-1] + PW'(1))
			: (CW+1)'(r_s[CW-1]);
		root_s <= fin_s;
	end

	assign root = root_s;

endmodule

### rtl/core/cau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_back
// Final rounding, saturation, result selection and output register.
// ----------------------------------------------------------------------------
module cau_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   v,
	input  cau_pkg::side_t         side,
	input  logic [cau_pkg::QW-1:0] quo_re,
	input  logic                   ovf_re,
	input  logic [cau_pkg::QW-1:0] quo_im,
	input  logic                   ovf_im,
	input  logic [cau_pkg::CW:0]   root,
	output logic                   done,
	output cau_pkg::result_t       result
);

	localparam int CW = cau_pkg::CW;
	localparam int QW = cau_pkg::QW;

	localparam logic [QW-1:0] POS_LIM = {2'b00, {(CW-1){1'b1}}};
	localparam logic [QW-1:0] NEG_LIM = {2'b01, {(CW-1){1'b0}}};

	// Round half away from zero on the magnitude, then apply sign and saturate.
	function automatic logic [CW:0] finish(input logic [QW-1:0] q, input logic o,
		input logic neg);
		logic [QW:0]   t;
		logic [QW-1:0] rq;
		logic [CW:0]   r;
		t  = {1'b0, q} + (QW+1)'(1);
		rq = t[QW:1];
		if (!neg) begin
			r = (o || rq > POS_LIM) ? {1'b1, cau_pkg::CMAX} : {1'b0, rq[CW-1:0]};
		end else begin
			r = (o || rq > NEG_LIM) ? {1'b1, cau_pkg::CMIN} : {1'b0, -rq[CW-1:0]};
		end
		return r;
	endfunction

	logic [CW:0]      f_re, f_im;
	logic             root_sat;
	cau_pkg::result_t res_nx;

	assign f_re     = finish(quo_re, ovf_re, side.neg_re);
	assign f_im     = finish(quo_im, ovf_im, side.neg_im);
	assign root_sat = root > {1'b0, cau_pkg::CMAX};

	always_comb begin
		res_nx.equal_flag = 1'b0;
		case (side.src)
			cau_pkg::SRC_DIV: begin
				res_nx.res_real = f_re[CW-1:0];
				res_nx.res_imag = f_im[CW-1:0];
				res_nx.status   = (f_re[CW] || f_im[CW]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
			end
			cau_pkg::SRC_SQRT: begin
				res_nx.res_real = root_sat ? cau_pkg::CMAX : root[CW-1:0];
				res_nx.res_imag = '0;
				res_nx.status   = root_sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
			end
			default: begin
				res_nx.res_real   = side.re;
				res_nx.res_imag   = side.im;
				res_nx.equal_flag = side.eq;
				res_nx.status     = side.st;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v;
		end
	end

	always_ff @(posedge clk) begin
		result <= res_nx;
	end

endmodule

### rtl/core/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Fixed-point complex ALU: add, subtract, multiply, divide, conjugate,
// modulus and compare on signed Q7.8 components.
// ----------------------------------------------------------------------------
// The unit is fully pipelined and accepts one item in every clock cycle;
// busy is always low, so an item is taken whenever start is high. Every item
// produces exactly one result, shown for a single cycle with done high.
// done and the result come out of the output register of cau_back together,
// after the two front stages and then the divider and root pipes. The
// receiver cannot hold results back, and results leave in the order the
// items came in. The divider resolves one quotient bit per pipeline stage;
// the square root runs beside it and the simple operations travel along a
// matching delay line so all results line up at the output register.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cau_pkg::item_t   item,
	output logic             done,
	output cau_pkg::result_t result
);

	localparam int CW = cau_pkg::CW;
	localparam int MW = cau_pkg::MW;
	localparam int PW = cau_pkg::PW;
	localparam int QW = cau_pkg::QW;
	// Latency of the divider and root pipes.
	localparam int DL = CW + 2;

	logic                 v_s2;
	cau_pkg::side_t       side_s2;
	logic [MW-1:0]        mag_re_s2, mag_im_s2, den_s2;
	logic [PW-1:0]        modsum_s2;
	logic [QW-1:0]        quo_re, quo_im;
	logic                 ovf_re, ovf_im;
	logic [CW:0]          root;

	// The pipeline never stalls, so the unit never refuses an item.
	assign busy = 1'b0;

	cau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (start && !busy),
		.item      (item),
		.v_s2      (v_s2),
		.side_s2   (side_s2),
		.mag_re_s2 (mag_re_s2),
		.mag_im_s2 (mag_im_s2),
		.den_s2    (den_s2),
		.modsum_s2 (modsum_s2)
	);

	// Real and imaginary parts each get their own divider.
	cau_divider u_div_re (
		.clk (clk),
		.mag (mag_re_s2),
		.den (den_s2),
		.quo (quo_re),
		.ovf (ovf_re)
	);

	cau_divider u_div_im (
		.clk (clk),
		.mag (mag_im_s2),
		.den (den_s2),
		.quo (quo_im),
		.ovf (ovf_im)
	);

	cau_sqrt u_sqrt (
		.clk  (clk),
		.sum  (modsum_s2),
		.root (root)
	);

	// Valid bits and per-item side information follow the arithmetic pipes.
	logic           dly_v_s    [0:DL-1];
	cau_pkg::side_t dly_side_s [0:DL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DL; i++) begin
				dly_v_s[i] <= 1'b0;
			end
		end else begin
			dly_v_s[0] <= v_s2;
			for (int i = 1; i < DL; i++) begin
				dly_v_s[i] <= dly_v_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		dly_side_s[0] <= side_s2;
		for (int i = 1; i < DL; i++) begin
			dly_side_s[i] <= dly_side_s[i-1];
		end
	end

	cau_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.v      (dly_v_s[DL-1]),
		.side   (dly_side_s[DL-1]),
		.quo_re (quo_re),
		.ovf_re (ovf_re),
		.quo_im (quo_im),
		.ovf_im (ovf_im),
		.root   (root),
		.done   (done),
		.result (result)
	);

endmodule
